>>> rtl/core/iptc_pkg.sv
// Shared types and constants for the instruction TLB, page table and cache lookup.
package iptc_pkg;

   localparam int VA_W        = 10;
   localparam int STAMP_W     = 19;
   localparam int PA_W        = 6;
   localparam int OFF_W       = 3;
   localparam int PAGE_W      = VA_W - OFF_W;
   localparam int PT_DEPTH    = 1 << PAGE_W;
   localparam int TLB_ENTRIES = 32;
   localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);
   localparam int MEM_FRAMES  = 8;
   localparam int FRAME_W     = $clog2(MEM_FRAMES);
   localparam int CACHE_WAYS  = 4;
   localparam int WAY_W       = $clog2(CACHE_WAYS);
   localparam int BLK_W       = 2;
   localparam int TAG_W       = PA_W - BLK_W;

   localparam logic [STAMP_W-1:0] FRAME_STAMP_CEIL = STAMP_W'(500000);
   // Every stamp is below this bound, so it acts as the TLB ceiling.
   localparam logic [STAMP_W:0]   TLB_STAMP_CEIL   = {1'b1, {STAMP_W{1'b0}}};

   typedef struct packed {
      logic [VA_W-1:0]    va;
      logic [STAMP_W-1:0] stamp;
      logic               tlb_hit;
      logic [FRAME_W-1:0] frame;
   } task_type;

   typedef struct packed {
      logic               valid;
      logic               evict;
      logic [FRAME_W-1:0] victim;
      logic [FRAME_W-1:0] frame;
   } fill_type;

endpackage

>>> rtl/core/iptc_queue.sv
// Two-word queue between the TLB front end and the walk and cache back end.
module iptc_queue import iptc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  task_type push_word,
   input  logic     pop,
   output task_type pop_word,
   output logic     empty,
   output logic     full
);

   task_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign pop_word = slot_ff[rd_ptr_ff];
   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);

endmodule

>>> rtl/core/iptc_front.sv
// Front end: fully associative TLB lookup, classification and refill.
module iptc_front import iptc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [VA_W-1:0]    req_va,
   input  logic [STAMP_W-1:0] req_stamp,
   input  fill_type           fill,
   output logic               push,
   output task_type           push_word,
   output logic               front_busy
);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_LOOK = 4'b0010,
      F_WAIT = 4'b0100,
      F_SCAN = 4'b1000
   } fstate_type;

   fstate_type state_ff, state_in;

   logic [TLB_ENTRIES-1:0] valid_ff;
   logic [PAGE_W-1:0]      page_ff  [TLB_ENTRIES];
   logic [FRAME_W-1:0]     frame_ff [TLB_ENTRIES];
   logic [STAMP_W-1:0]     last_ff  [TLB_ENTRIES];

   logic [VA_W-1:0]      va_ff, va_in;
   logic [STAMP_W-1:0]   stamp_ff, stamp_in;
   logic [FRAME_W-1:0]   fr_ff, fr_in;
   logic [TLB_IDX_W-1:0] idx_ff, idx_in;
   logic [STAMP_W:0]     best_ff, best_in;
   logic [TLB_IDX_W-1:0] best_idx_ff, best_idx_in;

   logic [PAGE_W-1:0]      page;
   logic                   hit_any, clr_any, free_any, scan_lt;
   logic [TLB_IDX_W-1:0]   hit_idx, clr_idx, free_idx;
   logic [TLB_ENTRIES-1:0] free_vec;
   logic                   touch_en, clr_en, wr_en;
   logic [TLB_IDX_W-1:0]   wr_idx;
   logic [FRAME_W-1:0]     wr_frame;

   assign page = va_ff[VA_W-1:OFF_W];

   always_comb begin
      hit_any  = 1'b0;
      hit_idx  = '0;
      clr_any  = 1'b0;
      clr_idx  = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && page_ff[i] == page) begin
            hit_any = 1'b1;
            hit_idx = TLB_IDX_W'(i);
         end
         if (valid_ff[i] && frame_ff[i] == fill.victim) begin
            clr_any = 1'b1;
            clr_idx = TLB_IDX_W'(i);
         end
      end
      free_vec = ~valid_ff;
      if (fill.evict && clr_any) begin
         free_vec[clr_idx] = 1'b1;
      end
      free_any = 1'b0;
      free_idx = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            free_any = 1'b1;
            free_idx = TLB_IDX_W'(i);
         end
      end
   end

   assign scan_lt = {1'b0, last_ff[idx_ff]} < best_ff;

   always_comb begin
      state_in    = state_ff;
      va_in       = va_ff;
      stamp_in    = stamp_ff;
      fr_in       = fr_ff;
      idx_in      = idx_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      push        = 1'b0;
      push_word   = '{va: va_ff, stamp: stamp_ff, tlb_hit: hit_any,
                      frame: hit_any ? frame_ff[hit_idx] : '0};
      touch_en    = 1'b0;
      clr_en      = 1'b0;
      wr_en       = 1'b0;
      wr_idx      = free_idx;
      wr_frame    = fill.frame;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               va_in    = req_va;
               stamp_in = req_stamp;
               state_in = F_LOOK;
            end
         end
         F_LOOK: begin
            push     = 1'b1;
            touch_en = hit_any;
            state_in = hit_any ? F_IDLE : F_WAIT;
         end
         F_WAIT: begin
            if (fill.valid) begin
               fr_in  = fill.frame;
               clr_en = fill.evict && clr_any;
               if (free_any) begin
                  wr_en    = 1'b1;
                  state_in = F_IDLE;
               end else begin
                  idx_in      = '0;
                  best_in     = TLB_STAMP_CEIL;
                  best_idx_in = '0;
                  state_in    = F_SCAN;
               end
            end
         end
         F_SCAN: begin
            if (scan_lt) begin
               best_in     = {1'b0, last_ff[idx_ff]};
               best_idx_in = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == TLB_IDX_W'(TLB_ENTRIES - 1)) begin
               wr_en    = 1'b1;
               wr_idx   = scan_lt ? idx_ff : best_idx_ff;
               wr_frame = fr_ff;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (clr_en) begin
            valid_ff[clr_idx] <= 1'b0;
         end
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
      va_ff       <= va_in;
      stamp_ff    <= stamp_in;
      fr_ff       <= fr_in;
      idx_ff      <= idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      if (touch_en) begin
         last_ff[hit_idx] <= stamp_ff;
      end
      if (clr_en) begin
         page_ff[clr_idx]  <= '0;
         frame_ff[clr_idx] <= '0;
      end
      if (wr_en) begin
         page_ff[wr_idx]  <= page;
         frame_ff[wr_idx] <= wr_frame;
         last_ff[wr_idx]  <= stamp_ff;
      end
   end

   assign front_busy = (state_ff != F_IDLE);

endmodule

>>> rtl/core/iptc_back.sv
// Back end: page-table walk, frame allocation and eviction, and cache lookup.
module iptc_back import iptc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  task_type           q_word,
   output logic               pop,
   output fill_type           fill,
   output logic               back_busy,
   output logic               rsp_valid,
   output logic [PA_W-1:0]    rsp_phys_addr,
   output logic               rsp_tlb_hit,
   output logic               rsp_pte_hit,
   output logic               rsp_cache_hit
);

   typedef enum logic [4:0] {
      B_IDLE  = 5'b00001,
      B_WALK  = 5'b00010,
      B_PTHIT = 5'b00100,
      B_FSCAN = 5'b01000,
      B_CACHE = 5'b10000
   } bstate_type;

   bstate_type state_ff, state_in;

   task_type           task_ff, task_in;
   logic [FRAME_W-1:0] cur_ff, cur_in;
   logic               pte_hit_ff, pte_hit_in;

   logic [PT_DEPTH-1:0] pt_valid_ff;
   logic [FRAME_W-1:0]  pt_mem [PT_DEPTH];
   logic [FRAME_W-1:0]  pt_rd_ff;

   logic [MEM_FRAMES-1:0] fvalid_ff;
   logic [STAMP_W-1:0]    flast_ff [MEM_FRAMES];
   logic [PAGE_W-1:0]     fpage_ff [MEM_FRAMES];
   logic [FRAME_W-1:0]    fidx_ff, fidx_in;
   logic [STAMP_W-1:0]    fbest_ff, fbest_in;
   logic [FRAME_W-1:0]    fbest_idx_ff, fbest_idx_in;

   logic [CACHE_WAYS-1:0] lv_ff, lmru_ff;
   logic [TAG_W-1:0]      ltag_ff [CACHE_WAYS];

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PA_W-1:0]    rsp_pa_ff, rsp_pa_in;
   logic               rsp_tlb_ff, rsp_tlb_in;
   logic               rsp_pte_ff, rsp_pte_in;
   logic               rsp_cache_ff, rsp_cache_in;

   logic [PAGE_W-1:0]  page;
   logic               ffree_any, fscan_lt;
   logic [FRAME_W-1:0] ffree_idx;
   logic               alloc_en, alloc_evict, touch_en, cache_en;
   logic [FRAME_W-1:0] alloc_frame;

   logic [PA_W-1:0]       pa;
   logic [TAG_W-1:0]      tag;
   logic                  c_hit, c_ok;
   logic [WAY_W-1:0]      hit_way, inv_way, old_way, c_way;
   logic                  inv_any, old_any;
   logic [CACHE_WAYS-1:0] mru_new;

   assign page     = task_ff.va[VA_W-1:OFF_W];
   assign fscan_lt = flast_ff[fidx_ff] < fbest_ff;

   always_comb begin
      ffree_any = 1'b0;
      ffree_idx = '0;
      for (int i = MEM_FRAMES - 1; i >= 0; i--) begin
         if (!fvalid_ff[i]) begin
            ffree_any = 1'b1;
            ffree_idx = FRAME_W'(i);
         end
      end
   end

   always_comb begin
      pa      = {cur_ff, task_ff.va[OFF_W-1:0]};
      tag     = pa[PA_W-1:BLK_W];
      c_hit   = 1'b0;
      hit_way = '0;
      inv_any = 1'b0;
      inv_way = '0;
      old_any = 1'b0;
      old_way = '0;
      for (int i = CACHE_WAYS - 1; i >= 0; i--) begin
         if (lv_ff[i] && ltag_ff[i] == tag) begin
            c_hit   = 1'b1;
            hit_way = WAY_W'(i);
         end
         if (!lv_ff[i]) begin
            inv_any = 1'b1;
            inv_way = WAY_W'(i);
         end
         if (!lmru_ff[i]) begin
            old_any = 1'b1;
            old_way = WAY_W'(i);
         end
      end
      c_ok  = c_hit || inv_any || old_any;
      c_way = c_hit ? hit_way : (inv_any ? inv_way : old_way);
      mru_new = lmru_ff;
      mru_new[c_way] = 1'b1;
      if (&mru_new) begin
         mru_new = '0;
         if (CACHE_WAYS > 1) begin
            mru_new[c_way] = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      task_in      = task_ff;
      cur_in       = cur_ff;
      pte_hit_in   = pte_hit_ff;
      fidx_in      = fidx_ff;
      fbest_in     = fbest_ff;
      fbest_idx_in = fbest_idx_ff;
      pop          = 1'b0;
      alloc_en     = 1'b0;
      alloc_evict  = 1'b0;
      alloc_frame  = ffree_idx;
      touch_en     = 1'b0;
      cache_en     = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_pa_in    = rsp_pa_ff;
      rsp_tlb_in   = rsp_tlb_ff;
      rsp_pte_in   = rsp_pte_ff;
      rsp_cache_in = rsp_cache_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               pop        = 1'b1;
               task_in    = q_word;
               cur_in     = q_word.frame;
               pte_hit_in = 1'b1;
               state_in   = q_word.tlb_hit ? B_CACHE : B_WALK;
            end
         end
         B_WALK: begin
            if (pt_valid_ff[page]) begin
               state_in = B_PTHIT;
            end else begin
               pte_hit_in = 1'b0;
               if (ffree_any) begin
                  alloc_en = 1'b1;
                  cur_in   = ffree_idx;
                  state_in = B_CACHE;
               end else begin
                  fidx_in      = '0;
                  fbest_in     = FRAME_STAMP_CEIL;
                  fbest_idx_in = '0;
                  state_in     = B_FSCAN;
               end
            end
         end
         B_PTHIT: begin
            touch_en = 1'b1;
            cur_in   = pt_rd_ff;
            state_in = B_CACHE;
         end
         B_FSCAN: begin
            if (fscan_lt) begin
               fbest_in     = flast_ff[fidx_ff];
               fbest_idx_in = fidx_ff;
            end
            fidx_in = fidx_ff + 1'b1;
            if (fidx_ff == FRAME_W'(MEM_FRAMES - 1)) begin
               alloc_en    = 1'b1;
               alloc_evict = 1'b1;
               alloc_frame = fscan_lt ? fidx_ff : fbest_idx_ff;
               cur_in      = alloc_frame;
               state_in    = B_CACHE;
            end
         end
         B_CACHE: begin
            cache_en     = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_pa_in    = pa;
            rsp_tlb_in   = task_ff.tlb_hit;
            rsp_pte_in   = pte_hit_ff;
            rsp_cache_in = c_hit;
            state_in     = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      fill.valid  = alloc_en || touch_en;
      fill.evict  = alloc_evict;
      fill.victim = alloc_frame;
      fill.frame  = touch_en ? pt_rd_ff : alloc_frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         pt_valid_ff  <= '0;
         fvalid_ff    <= '0;
         lv_ff        <= '0;
         lmru_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (alloc_en) begin
            fvalid_ff[alloc_frame] <= 1'b1;
            if (alloc_evict) begin
               pt_valid_ff[fpage_ff[alloc_frame]] <= 1'b0;
               for (int k = 0; k < CACHE_WAYS; k++) begin
                  if (ltag_ff[k][TAG_W-1:OFF_W-BLK_W] == alloc_frame) begin
                     lv_ff[k]   <= 1'b0;
                     lmru_ff[k] <= 1'b0;
                  end
               end
            end
            pt_valid_ff[page] <= 1'b1;
         end
         if (cache_en && c_ok) begin
            lmru_ff <= mru_new;
            if (!c_hit) begin
               lv_ff[c_way] <= 1'b1;
            end
         end
      end
      task_ff      <= task_in;
      cur_ff       <= cur_in;
      pte_hit_ff   <= pte_hit_in;
      fidx_ff      <= fidx_in;
      fbest_ff     <= fbest_in;
      fbest_idx_ff <= fbest_idx_in;
      rsp_pa_ff    <= rsp_pa_in;
      rsp_tlb_ff   <= rsp_tlb_in;
      rsp_pte_ff   <= rsp_pte_in;
      rsp_cache_ff <= rsp_cache_in;
      pt_rd_ff     <= pt_mem[page];
      if (alloc_en) begin
         pt_mem[page]          <= alloc_frame;
         flast_ff[alloc_frame] <= task_ff.stamp;
         fpage_ff[alloc_frame] <= page;
      end
      if (touch_en) begin
         flast_ff[pt_rd_ff] <= task_ff.stamp;
      end
      if (cache_en && c_ok && !c_hit) begin
         ltag_ff[c_way] <= tag;
      end
   end

   assign back_busy     = (state_ff != B_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_phys_addr = rsp_pa_ff;
   assign rsp_tlb_hit   = rsp_tlb_ff;
   assign rsp_pte_hit   = rsp_pte_ff;
   assign rsp_cache_hit = rsp_cache_ff;

endmodule

>>> rtl/core/itlb_page_table_cache_lookup.sv
// Top level of the instruction TLB, page table and cache lookup.
// One fetch word is taken at a time, and its result appears on the rsp_ ports for one cycle
// with rsp_valid high; it must be captured then. A TLB hit goes from the queue straight to
// the cache lookup. A TLB miss walks the page table, and a page table hit then reads the
// frame before the cache lookup; a page fault with a free frame allocates it in the walk.
// A page fault with all frames in use adds a scan of the frame stamps. When the TLB is
// full, its refill scans all 32 entry stamps, one per cycle, once the back end reports the
// frame, and busy stays high until that scan ends.
module itlb_page_table_cache_lookup import iptc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [VA_W-1:0]    req_virt_addr,
   input  logic [STAMP_W-1:0] req_stamp,
   output logic               rsp_valid,
   output logic [PA_W-1:0]    rsp_phys_addr,
   output logic               rsp_tlb_hit,
   output logic               rsp_pte_hit,
   output logic               rsp_cache_hit
);

   logic     accept, front_busy, back_busy;
   logic     q_push, q_pop, q_empty, q_full;
   task_type push_word, pop_word;
   fill_type fill;

   assign busy   = front_busy || !q_empty || back_busy;
   assign accept = start && !busy;

   iptc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_va     (req_virt_addr),
      .req_stamp  (req_stamp),
      .fill       (fill),
      .push       (q_push),
      .push_word  (push_word),
      .front_busy (front_busy)
   );

   iptc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (push_word),
      .pop       (q_pop),
      .pop_word  (pop_word),
      .empty     (q_empty),
      .full      (q_full)
   );

   iptc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_word        (pop_word),
      .pop           (q_pop),
      .fill          (fill),
      .back_busy     (back_busy),
      .rsp_valid     (rsp_valid),
      .rsp_phys_addr (rsp_phys_addr),
      .rsp_tlb_hit   (rsp_tlb_hit),
      .rsp_pte_hit   (rsp_pte_hit),
      .rsp_cache_hit (rsp_cache_hit)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("Queue pushed while full.");

   a_tlb_hit_implies_pte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tlb_hit |-> rsp_pte_hit)
      else $error("TLB hit reported with a page fault.");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Two result strobes in a row.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("Block not busy after taking a word.");

endmodule

>>> tb/sv/itlb_page_table_cache_lookup_checker.sv
// Checker that predicts each lookup result and compares it with the block's output.
`timescale 1ns / 1ps
module itlb_page_table_cache_lookup_checker import iptc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [VA_W-1:0]    req_virt_addr,
   input  logic [STAMP_W-1:0] req_stamp,
   input  logic               rsp_valid,
   input  logic [PA_W-1:0]    rsp_phys_addr,
   input  logic               rsp_tlb_hit,
   input  logic               rsp_pte_hit,
   input  logic               rsp_cache_hit,
   output int                 fail_count,
   output int                 pending
);

   typedef struct {
      logic [PA_W-1:0] pa;
      logic            tlb_hit;
      logic            pte_hit;
      logic            cache_hit;
   } lookup_type;

   lookup_type expected_lookups[$];

   logic               tv[TLB_ENTRIES];
   logic [PAGE_W-1:0]  tpage[TLB_ENTRIES];
   logic [FRAME_W-1:0] tframe[TLB_ENTRIES];
   logic [STAMP_W-1:0] tstamp[TLB_ENTRIES];
   logic               pv[PT_DEPTH];
   logic [FRAME_W-1:0] pframe[PT_DEPTH];
   logic               fv[MEM_FRAMES];
   logic [STAMP_W-1:0] fstamp[MEM_FRAMES];
   logic               lv[CACHE_WAYS];
   logic [TAG_W-1:0]   ltag[CACHE_WAYS];
   logic               lmru[CACHE_WAYS];
   logic [FRAME_W-1:0] cur;

   assign pending = expected_lookups.size();

   task automatic clear_model();
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         tv[i] = 0; tpage[i] = 0; tframe[i] = 0; tstamp[i] = 0;
      end
      for (int i = 0; i < PT_DEPTH; i++) begin
         pv[i] = 0; pframe[i] = 0;
      end
      for (int i = 0; i < MEM_FRAMES; i++) begin
         fv[i] = 0; fstamp[i] = 0;
      end
      for (int i = 0; i < CACHE_WAYS; i++) begin
         lv[i] = 0; ltag[i] = 0; lmru[i] = 0;
      end
      cur = 0;
   endtask

   function automatic int alloc_frame(logic [STAMP_W-1:0] s);
      int victim;
      int best;
      victim = 0;
      best = 500000;
      for (int i = 0; i < MEM_FRAMES; i++) begin
         if (!fv[i]) begin
            fv[i] = 1; fstamp[i] = s;
            return i;
         end
      end
      for (int i = 0; i < MEM_FRAMES; i++) begin
         if (int'(fstamp[i]) < best) begin
            best = fstamp[i]; victim = i;
         end
      end
      fstamp[victim] = s;
      for (int i = 0; i < PT_DEPTH; i++) begin
         if (pv[i] && pframe[i] == victim) begin
            pv[i] = 0; pframe[i] = 0;
         end
      end
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         if (tv[i] && tframe[i] == victim) begin
            tv[i] = 0; tframe[i] = 0; tpage[i] = 0;
            break;
         end
      end
      for (int k = 0; k < CACHE_WAYS; k++) begin
         if ((int'(ltag[k]) * 4) / 8 == victim) begin
            lmru[k] = 0; lv[k] = 0;
         end
      end
      return victim;
   endfunction

   function automatic void touch(int way);
      bool_all: begin
         lmru[way] = 1;
         for (int k = 0; k < CACHE_WAYS; k++)
            if (!lmru[k]) disable bool_all;
         for (int k = 0; k < CACHE_WAYS; k++)
            if (k != way) lmru[k] = 0;
      end
   endfunction

   function automatic logic cache_lookup(logic [PA_W-1:0] pa);
      logic [TAG_W-1:0] tag;
      tag = pa[PA_W-1:BLK_W];
      for (int i = 0; i < CACHE_WAYS; i++) begin
         if (lv[i] && ltag[i] == tag) begin
            touch(i);
            return 1;
         end
      end
      for (int i = 0; i < CACHE_WAYS; i++) begin
         if (!lv[i]) begin
            lv[i] = 1; ltag[i] = tag; touch(i);
            return 0;
         end
      end
      for (int i = 0; i < CACHE_WAYS; i++) begin
         if (!lmru[i]) begin
            lv[i] = 1; ltag[i] = tag; touch(i);
            return 0;
         end
      end
      return 0;
   endfunction

   function automatic lookup_type predict_lookup(logic [VA_W-1:0] va, logic [STAMP_W-1:0] s);
      lookup_type r;
      logic [PAGE_W-1:0] page;
      int slot;
      int best;
      bit found;
      page = va[VA_W-1:OFF_W];
      r.tlb_hit = 0;
      r.pte_hit = 1;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         if (tv[i] && tpage[i] == page) begin
            r.tlb_hit = 1; cur = tframe[i]; tstamp[i] = s;
            break;
         end
      end
      if (!r.tlb_hit) begin
         if (pv[page]) begin
            cur = pframe[page]; fstamp[cur] = s;
         end else begin
            r.pte_hit = 0;
            cur = FRAME_W'(alloc_frame(s));
            pv[page] = 1; pframe[page] = cur;
         end
         slot = 0; found = 0; best = 1 << 20;
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (!tv[i]) begin
               slot = i; found = 1;
               break;
            end
         end
         if (!found) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
               if (int'(tstamp[i]) < best) begin
                  best = tstamp[i]; slot = i;
               end
            end
         end
         tv[slot] = 1; tpage[slot] = page; tframe[slot] = cur; tstamp[slot] = s;
      end
      r.pa = {cur, va[OFF_W-1:0]};
      r.cache_hit = cache_lookup(r.pa);
      return r;
   endfunction

   always @(posedge clock) begin
      lookup_type e;
      if (reset) begin
         clear_model();
         expected_lookups.delete();
         fail_count <= 0;
      end else begin
         if (start && !busy) expected_lookups.push_back(predict_lookup(req_virt_addr, req_stamp));
         if (rsp_valid) begin
            if (expected_lookups.size() == 0) begin
               $error("unexpected result word phys_addr %0d", rsp_phys_addr);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_lookups.pop_front();
               if (e.pa !== rsp_phys_addr || e.tlb_hit !== rsp_tlb_hit ||
                   e.pte_hit !== rsp_pte_hit || e.cache_hit !== rsp_cache_hit) begin
                  if (e.pa !== rsp_phys_addr)
                     $error("phys_addr expected %0d actual %0d", e.pa, rsp_phys_addr);
                  if (e.tlb_hit !== rsp_tlb_hit)
                     $error("tlb_hit expected %0d actual %0d", e.tlb_hit, rsp_tlb_hit);
                  if (e.pte_hit !== rsp_pte_hit)
                     $error("pte_hit expected %0d actual %0d", e.pte_hit, rsp_pte_hit);
                  if (e.cache_hit !== rsp_cache_hit)
                     $error("cache_hit expected %0d actual %0d", e.cache_hit, rsp_cache_hit);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

>>> tb/sv/itlb_page_table_cache_lookup_tb.sv
// Testbench top that drives fetch words into the lookup block and reports the verdict.
`timescale 1ns / 1ps
module itlb_page_table_cache_lookup_tb;
   import iptc_pkg::*;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic [VA_W-1:0]    req_virt_addr = 0;
   logic [STAMP_W-1:0] req_stamp = 0;
   logic               rsp_valid;
   logic [PA_W-1:0]    rsp_phys_addr;
   logic               rsp_tlb_hit;
   logic               rsp_pte_hit;
   logic               rsp_cache_hit;
   int                 fail_count;
   int                 pending;
   int                 cycles = 0;

   localparam int CYCLE_LIMIT = 400000;

   always #10 clock = ~clock;

   itlb_page_table_cache_lookup u_top (.*);

   itlb_page_table_cache_lookup_checker u_checker (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_word(logic [VA_W-1:0] va, logic [STAMP_W-1:0] s, bit idle_ok);
      int gap;
      if (idle_ok && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_virt_addr <= va;
      req_stamp <= s;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      logic [VA_W-1:0] va;
      logic [VA_W-1:0] hot[16];
      int s;
      int mode;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: address extremes, stamp extremes, repeats, then enough pages to fault.
      send_word(0, 0, 0);
      send_word(0, 1, 0);
      send_word(10'h3FF, 499999, 0);
      send_word(10'h3FF, 2, 0);
      send_word(10'h3F8, 19'h7FFFF, 0);
      for (int i = 1; i <= 12; i++) send_word(VA_W'(i * 8 + i % 8), 19'(i * 3), 0);
      send_word(4, 500000, 0);
      send_word(0, 500001, 0);
      s = 100;
      for (int i = 0; i < 16; i++) hot[i] = VA_W'($urandom);
      for (int n = 0; n < 1100; n++) begin
         mode = $urandom_range(0, 9);
         if (mode < 5) va = hot[$urandom_range(0, 15)] ^ VA_W'($urandom_range(0, 7));
         else if (mode < 9) va = VA_W'($urandom);
         else begin
            va = {VA_W{1'b1}};
            hot[$urandom_range(0, 15)] = VA_W'($urandom);
         end
         if ($urandom_range(0, 19) == 0) s = $urandom_range(0, 524287);
         else s = (s + $urandom_range(1, 20)) % 524288;
         send_word(va, 19'(s), n < 950);
      end
      start <= 0;
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
